>>> sv/conv3x3_clamp_rgb_unit_assert.svh
// Assertion helpers for the convolution unit.
// Both macros sample on the rising edge of clk and are quiet while rst is high.
`ifndef CONV3X3_CLAMP_RGB_UNIT_ASSERT_SVH
`define CONV3X3_CLAMP_RGB_UNIT_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CV3_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge outside reset.
`define CV3_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

>>> sv/cv3_pkg.sv
`default_nettype none

package cv3_pkg;

  // Mask geometry and pixel layout.
  localparam int TAPS     = 9;
  localparam int COEF_W   = 7;
  localparam int CHAN_W   = 8;
  localparam int CHANNELS = 3;
  localparam int PIX_W    = CHAN_W * CHANNELS;

  // Configuration register map.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_COEFS   = 2'd2;

  // Register defaults: 640 x 480 frame, all nine coefficients equal to one.
  localparam logic [10:0]            WIDTH_RESET  = 11'd640;
  localparam logic [15:0]            HEIGHT_RESET = 16'd480;
  localparam logic [CFG_DATA_W-1:0]  MASK_RESET   = {TAPS{7'd1}};

  // Normalization: clamp the weighted sum to 0..9*255, add 4, divide by 9.
  // The divide is x * 7282 >> 16, exact for every x up to 2299.
  localparam int          SUM_MAX    = 2295;
  localparam logic [11:0] ROUND_BIAS = 12'd4;
  localparam logic [12:0] DIV_RECIP  = 13'd7282;
  localparam int          DIV_SHIFT  = 16;

  // Output queue.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = 3;
  localparam int OUT_CNT_W = 4;

  // Frame position flags that travel with a pixel through the pipeline.
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } side_t;

  // One queued result.
  typedef struct packed {
    side_t            side;
    logic [PIX_W-1:0] pix;
  } res_t;

  // Signed coefficient k of the packed mask.
  function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_DATA_W-1:0] mask,
                                                    input int unsigned k);
    return signed'(mask[COEF_W*k +: COEF_W]);
  endfunction

endpackage

`default_nettype wire

>>> sv/conv3x3_clamp_rgb_unit.sv
// 3x3 convolution over raster RGB pixels, one pixel accepted per clock while s_tready
// is high. Interior pixels give results on m_tvalid via the line store read, the product
// and sum registers and the output queue. The rate of 1 pixel per cycle is set by the
// shared line store read-modify-write; an 8-entry queue absorbs downstream stalls.
// Reset (rst, synchronous): counters, window, pipeline and queue are cleared and the
// registers return to 640 x 480 with a box mask; the line store is not cleared.
`default_nettype none
`include "conv3x3_clamp_rgb_unit_assert.svh"

module conv3x3_clamp_rgb_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [cv3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cv3_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Pixel input.
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  input  wire logic [cv3_pkg::PIX_W-1:0]        s_tdata,  // blue_in, green_in, red_in
  // Filtered output.
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  output      logic [cv3_pkg::PIX_W-1:0]        m_tdata,  // blue_out, green_out, red_out
  output      logic                             m_tlast,  // row_end
  output      logic                             m_tuser   // frame_end
);
  import cv3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int LW = (WB > 11) ? WB : 11;

  // Configuration registers.
  logic [10:0]           image_width;
  logic [15:0]           image_height;
  logic [CFG_DATA_W-1:0] mask_coefficients;

  // Frame position.
  logic [CW-1:0] col_count;
  logic [15:0]   row_count;
  logic [LW-1:0] w_ext;
  logic [LW-1:0] w_lim;
  logic [15:0]   h_lim;
  logic          last_col;
  logic          last_row;
  logic          interior;
  logic          accept;

  // Stage 1: line store data arrives.
  logic             v1;
  logic             s1_int;
  side_t            s1_side;
  logic [PIX_W-1:0] s1_cur;
  logic [CW-1:0]    s1_addr;
  logic [2*PIX_W-1:0] ram_rdata;
  logic [PIX_W-1:0] top;
  logic [PIX_W-1:0] mid;
  logic [PIX_W-1:0] window_cols [6];
  logic [TAPS-1:0][PIX_W-1:0] win;
  logic [CHANNELS-1:0][TAPS-1:0][CHAN_W-1:0] chan_taps;
  logic [CHANNELS-1:0][CHAN_W-1:0] chan_out;

  // Stages 2 and 3: filter arithmetic.
  logic  v2;
  side_t s2_side;
  logic  v3;
  side_t s3_side;

  // Output queue.
  res_t                 fifo_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic [OUT_CNT_W-1:0] pending;
  logic                 push;
  logic                 pop;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= WIDTH_RESET;
      image_height      <= HEIGHT_RESET;
      mask_coefficients <= MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width       <= cfg_data[10:0];
        CFG_IMAGE_HEIGHT: image_height      <= cfg_data[15:0];
        CFG_MASK_COEFS:   mask_coefficients <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry and position flags of the incoming pixel.
  always_comb begin
    w_ext = LW'(image_width);
    if (w_ext < LW'(3)) begin
      w_lim = LW'(3);
    end else if (w_ext > LW'(MAX_WIDTH)) begin
      w_lim = LW'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    h_lim    = (image_height < 16'd3) ? 16'd3 : image_height;
    last_col = LW'(col_count) >= (w_lim - LW'(1));
    last_row = row_count >= (h_lim - 16'd1);
    interior = (row_count >= 16'd2) && (col_count >= CW'(2));
  end

  // The input is held back only when the queue could not take every result in flight.
  assign pending  = fifo_count + OUT_CNT_W'(v1 && s1_int) + OUT_CNT_W'(v2) + OUT_CNT_W'(v3);
  assign s_tready = pending < OUT_CNT_W'(OUT_DEPTH);
  assign accept   = s_tvalid && s_tready;

  // Column and row counters advance on every accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? 16'd0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // Both line stores share one RAM entry per column: upper row high, lower row low.
  // Consecutive pixels always touch different columns, so the write-back of one
  // pixel never meets the read of the next.
  cv3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (v1),
    .waddr (s1_addr),
    .wdata ({mid, s1_cur}),
    .re    (accept),
    .raddr (col_count),
    .rdata (ram_rdata)
  );

  // Stage 1 control and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_int            <= interior;
      s1_side.row_end   <= last_col;
      s1_side.frame_end <= last_col && last_row;
      s1_cur            <= s_tdata;
      s1_addr           <= col_count;
    end
  end

  assign top = ram_rdata[2*PIX_W-1:PIX_W];
  assign mid = ram_rdata[PIX_W-1:0];

  // Window: two stored columns plus the column just read.
  always_comb begin
    for (int u = 0; u < 3; u++) begin
      win[3*u]     = window_cols[u];
      win[3*u + 1] = window_cols[3 + u];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = s1_cur;
  end

  // Shift the window by one column per pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window_cols[i] <= '0;
      end
    end else if (v1) begin
      for (int i = 0; i < 3; i++) begin
        window_cols[i] <= window_cols[3 + i];
      end
      window_cols[3] <= top;
      window_cols[4] <= mid;
      window_cols[5] <= s1_cur;
    end
  end

  // One filter datapath per color channel.
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
      assign chan_taps[ch][k] = win[k][CHAN_W*ch +: CHAN_W];
    end
    cv3_chan u_chan (
      .clk    (clk),
      .mask   (mask_coefficients),
      .taps   (chan_taps[ch]),
      .result (chan_out[ch])
    );
  end

  // Only interior pixels continue past stage 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= v1 && s1_int;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    s2_side <= s1_side;
    s3_side <= s2_side;
  end

  // Output queue.
  assign push = v3;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr].side <= s3_side;
      fifo_mem[wr_ptr].pix  <= {chan_out[2], chan_out[1], chan_out[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fifo_count <= fifo_count + OUT_CNT_W'(1);
        2'b01:   fifo_count <= fifo_count - OUT_CNT_W'(1);
        default: ;
      endcase
    end
  end

  assign m_tvalid = fifo_count != '0;
  assign m_tdata  = fifo_mem[rd_ptr].pix;
  assign m_tlast  = fifo_mem[rd_ptr].side.row_end;
  assign m_tuser  = fifo_mem[rd_ptr].side.frame_end;

  // A result never arrives at a full queue.
  `CV3_ASSERT_IMP(a_queue_room, push, fifo_count < OUT_CNT_W'(OUT_DEPTH), "output queue overflow")
  // The line store write-back never targets the column being read.
  `CV3_ASSERT_IMP(a_ram_no_collide, accept && v1, s1_addr != col_count, "line store collision")
  // Results in flight plus queued never exceed the queue depth.
  `CV3_ASSERT_ALWAYS(a_credit_bound, pending <= OUT_CNT_W'(OUT_DEPTH), "credit count exceeded")

endmodule

`default_nettype wire

>>> sv/cv3_ram.sv
`default_nettype none

module cv3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/cv3_chan.sv
`default_nettype none

module cv3_chan (
  input  wire logic                                         clk,
  input  wire logic [cv3_pkg::CFG_DATA_W-1:0]               mask,
  input  wire logic [cv3_pkg::TAPS-1:0][cv3_pkg::CHAN_W-1:0] taps,
  output      logic [cv3_pkg::CHAN_W-1:0]                   result
);
  import cv3_pkg::*;

  logic signed [CHAN_W:0]   px_s   [TAPS];
  logic signed [COEF_W-1:0] cf_s   [TAPS];
  logic signed [15:0]       prod   [TAPS];
  logic signed [15:0]       prod_q [TAPS];
  logic signed [19:0]       sum;
  logic [11:0]              clamped;
  logic [11:0]              acc_q;
  logic [23:0]              qmul;

  // Nine products of sample and coefficient, registered.
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      px_s[k] = signed'({1'b0, taps[k]});
      cf_s[k] = coef(mask, k);
      prod[k] = 16'(px_s[k]) * 16'(cf_s[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < TAPS; k++) begin
      prod_q[k] <= prod[k];
    end
  end

  // Sum the products, clamp to the pixel range times nine, add the rounding bias.
  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum = sum + 20'(prod_q[k]);
    end
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > 20'(SUM_MAX)) begin
      clamped = 12'(SUM_MAX);
    end else begin
      clamped = sum[11:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_q <= clamped + ROUND_BIAS;
  end

  // Divide by nine through the reciprocal; the caller registers the result.
  assign qmul   = 24'(acc_q) * 24'(DIV_RECIP);
  assign result = qmul[DIV_SHIFT +: CHAN_W];

endmodule

`default_nettype wire
